FILE: src/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg
// Shared types, codes and sizes for the time ordered event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package toeq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FILL_W      = 5;
	localparam int TIME_W      = 32;
	localparam int TAG_W       = 16;

	// command codes
	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	// status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic              insert;
		logic              pop;
		logic [TIME_W-1:0] key_time;
		logic [TAG_W-1:0]  key_tag;
	} cell_op_t;

	// entry count shown on the result port, low bits only
	function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+FILL_W-1:0] wide;
		wide = {{FILL_W{1'b0}}, cnt};
		return wide[FILL_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/toeq_cell.sv
// ----------------------------------------------------------------------------
// toeq_cell
// One slot of the sorted queue: compares against the incoming key and
// shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module toeq_cell (
	input  wire logic                      clk,
	input  wire toeq_pkg::cell_op_t        op,
	input  wire logic                      head,
	input  wire logic                      occ,
	input  wire logic                      prev_occ,
	input  wire logic                      prev_ge,
	input  wire logic [toeq_pkg::TIME_W-1:0] prev_time,
	input  wire logic [toeq_pkg::TAG_W-1:0]  prev_tag,
	input  wire logic [toeq_pkg::TIME_W-1:0] next_time,
	input  wire logic [toeq_pkg::TAG_W-1:0]  next_tag,
	output logic                           ge,
	output logic [toeq_pkg::TIME_W-1:0]    slot_time,
	output logic [toeq_pkg::TAG_W-1:0]     slot_tag
);
	import toeq_pkg::*;

	logic [TIME_W-1:0] time_q;
	logic [TAG_W-1:0]  tag_q;
	logic              shift;
	logic              take_key;

	// the new event belongs at or before this slot; the head wins ties
	assign ge = occ & (head ? (time_q > op.key_time) : (time_q >= op.key_time));

	// move the neighbor down, or drop the new event in here
	assign shift    = prev_occ & prev_ge;
	assign take_key = ~shift & (ge | (~occ & prev_occ));

	// slot contents
	always_ff @(posedge clk) begin
		if (op.insert) begin
			if (shift) begin
				time_q <= prev_time;
				tag_q  <= prev_tag;
			end else if (take_key) begin
				time_q <= op.key_time;
				tag_q  <= op.key_tag;
			end
		end else if (op.pop) begin
			time_q <= next_time;
			tag_q  <= next_tag;
		end
	end

	assign slot_time = time_q;
	assign slot_tag  = tag_q;

endmodule

`default_nettype wire

FILE: src/time_ordered_event_queue_top.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue_top
// Bounded event queue held in ascending time order in a row of cells.
// ----------------------------------------------------------------------------
//   channel  | handshake              | beat
//   ---------+------------------------+-----------------------------------
//   command  | cmd_valid / cmd_stall  | command, event_time, event_tag
//   result   | res_valid / res_stall  | out_valid, out_time, out_tag,
//            |                        | status, fill_count
//
// One command beat per cycle while cmd_stall is low; its result beat is shown the next cycle.
// Every cell compares its slot with the new key in parallel, so on an insert
// or a pop every cell updates at once whatever the fill.
// Reset empties the queue at once; no clearing pass.
// cmd_stall is high while a result waits in the output register and
// res_stall holds it there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module time_ordered_event_queue_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic                          command,
	input  wire logic [toeq_pkg::TIME_W-1:0]   event_time,
	input  wire logic [toeq_pkg::TAG_W-1:0]    event_tag,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic                               out_valid,
	output logic [toeq_pkg::TIME_W-1:0]        out_time,
	output logic [toeq_pkg::TAG_W-1:0]         out_tag,
	output logic [1:0]                         status,
	output logic [toeq_pkg::FILL_W-1:0]        fill_count
);
	import toeq_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic              res_valid_q;
	logic              out_valid_q;
	logic [TIME_W-1:0] out_time_q;
	logic [TAG_W-1:0]  out_tag_q;
	status_t           status_q;
	logic [FILL_W-1:0] fill_q;

	logic              accept;
	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  count_nxt;
	cell_op_t          op;

	logic              cell_ge   [QUEUE_DEPTH];
	logic              cell_occ  [QUEUE_DEPTH];
	logic [TIME_W-1:0] cell_time [QUEUE_DEPTH];
	logic [TAG_W-1:0]  cell_tag  [QUEUE_DEPTH];

	// handshake
	assign cmd_stall = res_valid_q & res_stall;
	assign accept    = cmd_valid & ~cmd_stall;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	// operation broadcast to the cells
	always_comb begin
		op.insert   = accept & (command == CMD_INSERT) & ~full;
		op.pop      = accept & (command == CMD_POP) & ~empty;
		op.key_time = event_time;
		op.key_tag  = event_tag;
	end

	// next entry count
	always_comb begin
		count_nxt = count_q;
		if (op.insert) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (op.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// row of cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic              p_occ;
		logic              p_ge;
		logic [TIME_W-1:0] p_time;
		logic [TAG_W-1:0]  p_tag;
		logic [TIME_W-1:0] n_time;
		logic [TAG_W-1:0]  n_tag;

		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign p_occ  = 1'b1;
			assign p_ge   = 1'b0;
			assign p_time = event_time;
			assign p_tag  = event_tag;
		end else begin : g_inner
			assign p_occ  = cell_occ[i-1];
			assign p_ge   = cell_ge[i-1];
			assign p_time = cell_time[i-1];
			assign p_tag  = cell_tag[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign n_time = cell_time[i];
			assign n_tag  = cell_tag[i];
		end else begin : g_mid
			assign n_time = cell_time[i+1];
			assign n_tag  = cell_tag[i+1];
		end

		toeq_cell u_cell (
			.clk       (clk),
			.op        (op),
			.head      (i == 0),
			.occ       (cell_occ[i]),
			.prev_occ  (p_occ),
			.prev_ge   (p_ge),
			.prev_time (p_time),
			.prev_tag  (p_tag),
			.next_time (n_time),
			.next_tag  (n_tag),
			.ge        (cell_ge[i]),
			.slot_time (cell_time[i]),
			.slot_tag  (cell_tag[i])
		);
	end

	// entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid_q <= op.pop;
			out_time_q  <= op.pop ? cell_time[0] : '0;
			out_tag_q   <= op.pop ? cell_tag[0] : '0;
			fill_q      <= fill_of(count_nxt);
			if ((command == CMD_INSERT) && full) begin
				status_q <= STAT_FULL;
			end else if ((command == CMD_POP) && empty) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_OK;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign out_valid  = out_valid_q;
	assign out_time   = out_time_q;
	assign out_tag    = out_tag_q;
	assign status     = status_q;
	assign fill_count = fill_q;

endmodule

`default_nettype wire

FILE: src/toeq_checker.sv
// ----------------------------------------------------------------------------
// toeq_checker
// Port level checks on the event queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module toeq_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cmd_valid,
	input wire logic                        cmd_stall,
	input wire logic                        command,
	input wire logic [toeq_pkg::TIME_W-1:0] event_time,
	input wire logic [toeq_pkg::TAG_W-1:0]  event_tag,
	input wire logic                        res_valid,
	input wire logic                        res_stall,
	input wire logic                        out_valid,
	input wire logic [toeq_pkg::TIME_W-1:0] out_time,
	input wire logic [toeq_pkg::TAG_W-1:0]  out_tag,
	input wire logic [1:0]                  status,
	input wire logic [toeq_pkg::FILL_W-1:0] fill_count
);
	import toeq_pkg::*;

	// an accepted command beat shows its result on the next cycle
	a_cmd_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("command beat without a result beat");

	// a held result beat stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_time) && $stable(status))
		else $error("stalled result beat changed");

	// a returned event means the status is ok
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |-> status == STAT_OK)
		else $error("event returned with error status");

	// a pop on an empty queue leaves it empty and returns nothing
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_EMPTY |-> !out_valid && fill_count == '0
			&& out_time == '0 && out_tag == '0)
		else $error("empty pop result inconsistent");

	// a dropped insert reports a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_FULL |-> !out_valid
			&& fill_count == fill_of(CNT_W'(QUEUE_DEPTH)))
		else $error("full drop result inconsistent");

endmodule

bind time_ordered_event_queue_top toeq_checker u_toeq_checker (.*);

`default_nettype wire
